// File: rtl/core/eurm_pkg.sv
package eurm_pkg;

  // field widths
  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int POS_BITS       = 32;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;

  // phase: full turn is 2^PH_BITS
  localparam int PH_BITS  = 32;
  localparam int PH_SHIFT = PH_BITS - ANGLE_BITS;

  // CORDIC datapath, Q30
  localparam int Q_FRAC = 30;
  localparam int STAGES = 20;
  localparam int STG_W  = $clog2(STAGES);
  localparam int XY_W   = 33;
  localparam int Z_W    = 33;
  localparam int PROD_W = 2 * XY_W;
  localparam int SUM_W  = PROD_W + 1;

  // angle lanes
  localparam int NUM_AX   = 3;
  localparam int AX_YAW   = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_ROLL  = 2;

  localparam int NUM_COEF = 9;

  // gain-compensated 1.0
  localparam logic signed [XY_W-1:0] X_INIT = XY_W'(652032874);

  // quadrant fold limits
  localparam logic signed [Z_W-1:0] PH_QUARTER = Z_W'(1) <<< (PH_BITS - 2);
  localparam logic signed [Z_W-1:0] PH_HALF    = Z_W'(1) <<< (PH_BITS - 1);

  // rounding constants
  localparam logic signed [PROD_W-1:0] RND_Q   = PROD_W'(1) <<< (Q_FRAC - 1);
  localparam int                       FIN_SH  = 2 * Q_FRAC - COEF_FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  FIN_RND = SUM_W'(1) <<< (FIN_SH - 1);
  localparam logic signed [SUM_W-1:0]  COEF_LIM = SUM_W'(1) <<< COEF_FRAC_BITS;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [COEF_W-1:0]     coef_t;

  // one rotator's working set
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } rot_t;

  // item as it travels down the cell row
  typedef struct packed {
    rot_t [NUM_AX-1:0] rot;
    pos_t [2:0]        mv;
  } cell_t;

  // atan(2^-i) in full-turn phase units
  function automatic logic signed [Z_W-1:0] atan_val(input logic [STG_W-1:0] i);
    case (i)
      0:       return Z_W'(536870912);
      1:       return Z_W'(316933406);
      2:       return Z_W'(167458907);
      3:       return Z_W'(85004756);
      4:       return Z_W'(42667331);
      5:       return Z_W'(21354465);
      6:       return Z_W'(10679838);
      7:       return Z_W'(5340245);
      8:       return Z_W'(2670163);
      9:       return Z_W'(1335087);
      10:      return Z_W'(667544);
      11:      return Z_W'(333772);
      12:      return Z_W'(166886);
      13:      return Z_W'(83443);
      14:      return Z_W'(41722);
      15:      return Z_W'(20861);
      16:      return Z_W'(10430);
      17:      return Z_W'(5215);
      18:      return Z_W'(2608);
      19:      return Z_W'(1304);
      default: return '0;
    endcase
  endfunction

endpackage

// File: rtl/core/eurm_pose_if.sv
interface eurm_pose_if;
  import eurm_pkg::*;

  logic   valid;
  logic   ready;
  angle_t yaw;
  angle_t pitch;
  angle_t roll;
  pos_t   move_x;
  pos_t   move_y;
  pos_t   move_z;

  modport source (output valid, yaw, pitch, roll, move_x, move_y, move_z, input ready);
  modport sink (input valid, yaw, pitch, roll, move_x, move_y, move_z, output ready);
endinterface

// File: rtl/core/eurm_xform_if.sv
interface eurm_xform_if;
  import eurm_pkg::*;

  logic  valid;
  logic  ready;
  coef_t r00;
  coef_t r01;
  coef_t r02;
  coef_t r10;
  coef_t r11;
  coef_t r12;
  coef_t r20;
  coef_t r21;
  coef_t r22;
  pos_t  out_x;
  pos_t  out_y;
  pos_t  out_z;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  out_x, out_y, out_z, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                out_x, out_y, out_z, output ready);
endinterface

// File: rtl/core/eurm_fold.sv
module eurm_fold (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  eurm_pkg::angle_t yaw,
  input  eurm_pkg::angle_t pitch,
  input  eurm_pkg::angle_t roll,
  input  eurm_pkg::pos_t  move_x,
  input  eurm_pkg::pos_t  move_y,
  input  eurm_pkg::pos_t  move_z,
  output logic            out_vld,
  output eurm_pkg::cell_t out_data
);
  import eurm_pkg::*;

  angle_t ang [NUM_AX];
  cell_t  data_next;

  assign ang[AX_YAW]   = yaw;
  assign ang[AX_PITCH] = pitch;
  assign ang[AX_ROLL]  = roll;

  // scale to full-turn phase, fold into +-90 degrees
  always_comb begin
    logic [PH_BITS-1:0]    ph;
    logic signed [Z_W-1:0] z;
    data_next = '0;
    for (int k = 0; k < NUM_AX; k++) begin
      ph = PH_BITS'(ang[k]) << PH_SHIFT;
      z  = Z_W'($signed(ph));
      data_next.rot[k].x   = X_INIT;
      data_next.rot[k].y   = '0;
      data_next.rot[k].neg = 1'b0;
      if (z > PH_QUARTER) begin
        data_next.rot[k].z   = z - PH_HALF;
        data_next.rot[k].neg = 1'b1;
      end else if (z < -PH_QUARTER) begin
        data_next.rot[k].z   = z + PH_HALF;
        data_next.rot[k].neg = 1'b1;
      end else begin
        data_next.rot[k].z = z;
      end
    end
    data_next.mv[0] = move_x;
    data_next.mv[1] = move_y;
    data_next.mv[2] = move_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/eurm_cordic_cell.sv
module eurm_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [eurm_pkg::STG_W-1:0] stage,
  input  logic                       in_vld,
  input  eurm_pkg::cell_t            in_data,
  output logic                       out_vld,
  output eurm_pkg::cell_t            out_data
);
  import eurm_pkg::*;

  cell_t data_next;

  // one micro-rotation on each of the three angle lanes
  always_comb begin
    logic signed [XY_W-1:0] xi;
    logic signed [XY_W-1:0] yi;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  zi;
    logic signed [Z_W-1:0]  at;
    data_next = in_data;
    at = atan_val(stage);
    for (int k = 0; k < NUM_AX; k++) begin
      xi = in_data.rot[k].x;
      yi = in_data.rot[k].y;
      zi = in_data.rot[k].z;
      xs = xi >>> stage;
      ys = yi >>> stage;
      if (!zi[Z_W-1]) begin
        data_next.rot[k].x = xi - ys;
        data_next.rot[k].y = yi + xs;
        data_next.rot[k].z = zi - at;
      end else begin
        data_next.rot[k].x = xi + ys;
        data_next.rot[k].y = yi - xs;
        data_next.rot[k].z = zi + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/eurm_matrix.sv
module eurm_matrix (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  eurm_pkg::cell_t                       in_data,
  output logic                                  out_vld,
  output eurm_pkg::coef_t [eurm_pkg::NUM_COEF-1:0] coef,
  output eurm_pkg::pos_t  [2:0]                 mv
);
  import eurm_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;

  // stage 0: signed sine and cosine
  logic signed [XY_W-1:0]   cs_c [NUM_AX];
  logic signed [XY_W-1:0]   cs_s [NUM_AX];
  pos_t [2:0]               mv0;
  // stage 1: pair products
  logic signed [PROD_W-1:0] p_cysp;
  logic signed [PROD_W-1:0] p_sysp;
  logic signed [PROD_W-1:0] pb1 [NUM_COEF];
  logic signed [XY_W-1:0]   cr1;
  logic signed [XY_W-1:0]   sr1;
  pos_t [2:0]               mv1;
  // stage 2: leading pair rounded to Q30
  logic signed [XY_W-1:0]   cysp2;
  logic signed [XY_W-1:0]   sysp2;
  logic signed [PROD_W-1:0] pb2 [NUM_COEF];
  logic signed [XY_W-1:0]   cr2;
  logic signed [XY_W-1:0]   sr2;
  pos_t [2:0]               mv2;
  // stage 3: three-factor products
  logic signed [PROD_W-1:0] pa3 [4];
  logic signed [PROD_W-1:0] pb3 [NUM_COEF];
  pos_t [2:0]               mv3;
  // stage 4: Q60 sums
  logic signed [SUM_W-1:0]  sum4 [NUM_COEF];
  pos_t [2:0]               mv4;

  function automatic coef_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + FIN_RND) >>> FIN_SH;
    if (r > COEF_LIM) begin
      return COEF_W'(COEF_LIM);
    end else if (r < -COEF_LIM) begin
      return COEF_W'(-COEF_LIM);
    end
    return COEF_W'(r);
  endfunction

  // valid chain, frozen with the datapath on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_vld};
    end
  end

  assign out_vld = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0
      for (int k = 0; k < NUM_AX; k++) begin
        cs_c[k] <= in_data.rot[k].neg ? -in_data.rot[k].x : in_data.rot[k].x;
        cs_s[k] <= in_data.rot[k].neg ? -in_data.rot[k].y : in_data.rot[k].y;
      end
      mv0 <= in_data.mv;

      // stage 1
      p_cysp <= PROD_W'(cs_c[AX_YAW]) * PROD_W'(cs_s[AX_PITCH]);
      p_sysp <= PROD_W'(cs_s[AX_YAW]) * PROD_W'(cs_s[AX_PITCH]);
      pb1[0] <= PROD_W'(cs_c[AX_YAW]) * PROD_W'(cs_c[AX_PITCH]);
      pb1[1] <= PROD_W'(cs_s[AX_YAW]) * PROD_W'(cs_c[AX_ROLL]);
      pb1[2] <= PROD_W'(cs_s[AX_YAW]) * PROD_W'(cs_s[AX_ROLL]);
      pb1[3] <= PROD_W'(cs_s[AX_YAW]) * PROD_W'(cs_c[AX_PITCH]);
      pb1[4] <= PROD_W'(cs_c[AX_YAW]) * PROD_W'(cs_c[AX_ROLL]);
      pb1[5] <= PROD_W'(cs_c[AX_YAW]) * PROD_W'(cs_s[AX_ROLL]);
      pb1[6] <= PROD_W'(cs_s[AX_PITCH]) <<< Q_FRAC;
      pb1[7] <= PROD_W'(cs_c[AX_PITCH]) * PROD_W'(cs_s[AX_ROLL]);
      pb1[8] <= PROD_W'(cs_c[AX_PITCH]) * PROD_W'(cs_c[AX_ROLL]);
      cr1    <= cs_c[AX_ROLL];
      sr1    <= cs_s[AX_ROLL];
      mv1    <= mv0;

      // stage 2
      cysp2 <= XY_W'((p_cysp + RND_Q) >>> Q_FRAC);
      sysp2 <= XY_W'((p_sysp + RND_Q) >>> Q_FRAC);
      pb2   <= pb1;
      cr2   <= cr1;
      sr2   <= sr1;
      mv2   <= mv1;

      // stage 3
      pa3[0] <= PROD_W'(cysp2) * PROD_W'(sr2);
      pa3[1] <= PROD_W'(cysp2) * PROD_W'(cr2);
      pa3[2] <= PROD_W'(sysp2) * PROD_W'(sr2);
      pa3[3] <= PROD_W'(sysp2) * PROD_W'(cr2);
      pb3    <= pb2;
      mv3    <= mv2;

      // stage 4
      sum4[0] <= SUM_W'(pb3[0]);
      sum4[1] <= SUM_W'(pa3[0]) - SUM_W'(pb3[1]);
      sum4[2] <= SUM_W'(pa3[1]) + SUM_W'(pb3[2]);
      sum4[3] <= SUM_W'(pb3[3]);
      sum4[4] <= SUM_W'(pa3[2]) + SUM_W'(pb3[4]);
      sum4[5] <= SUM_W'(pa3[3]) - SUM_W'(pb3[5]);
      sum4[6] <= -SUM_W'(pb3[6]);
      sum4[7] <= SUM_W'(pb3[7]);
      sum4[8] <= SUM_W'(pb3[8]);
      mv4     <= mv3;

      // stage 5: output register
      for (int k = 0; k < NUM_COEF; k++) begin
        coef[k] <= round_sat(sum4[k]);
      end
      mv <= mv4;
    end
  end

endmodule

// File: rtl/core/euler_to_rotation_matrix.sv
// ZYX Euler angles to rigid transform.
// pose (sink): yaw, pitch, roll in binary radians plus a translation.
// xform (source): the nine coefficients of Rz(yaw)*Ry(pitch)*Rx(roll) in
// signed Q2.14, saturated to +-1.0, and the translation unchanged.
// Throughput: one item per cycle unless stalled. Path from acceptance to
// xform.valid: a register for phase scaling and quadrant fold, 20 cells of
// the CORDIC row (one micro-rotation each, all three angles side by side),
// then six product and rounding stages ending in the output register.
// Stall: the whole pipeline advances only while the output register is
// empty or being taken, so pose.ready follows xform.ready whenever
// xform.valid is high; items keep their order and none is dropped.
// Reset: clears every stage valid bit; no item is in flight afterwards.
module euler_to_rotation_matrix (
  input  logic          clk,
  input  logic          rst,
  eurm_pose_if.sink     pose,
  eurm_xform_if.source  xform
);
  import eurm_pkg::*;

  logic                  en;
  logic [STAGES:0]       row_vld;
  cell_t                 row [STAGES+1];
  coef_t [NUM_COEF-1:0]  coef;
  pos_t  [2:0]           mv_out;

  // pipeline enable
  assign en         = !xform.valid || xform.ready;
  assign pose.ready = en;

  eurm_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (pose.valid),
    .yaw      (pose.yaw),
    .pitch    (pose.pitch),
    .roll     (pose.roll),
    .move_x   (pose.move_x),
    .move_y   (pose.move_y),
    .move_z   (pose.move_z),
    .out_vld  (row_vld[0]),
    .out_data (row[0])
  );

  // CORDIC row
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    eurm_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .stage    (STG_W'(g)),
      .in_vld   (row_vld[g]),
      .in_data  (row[g]),
      .out_vld  (row_vld[g+1]),
      .out_data (row[g+1])
    );
  end

  eurm_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (row_vld[STAGES]),
    .in_data (row[STAGES]),
    .out_vld (xform.valid),
    .coef    (coef),
    .mv      (mv_out)
  );

  assign xform.r00   = coef[0];
  assign xform.r01   = coef[1];
  assign xform.r02   = coef[2];
  assign xform.r10   = coef[3];
  assign xform.r11   = coef[4];
  assign xform.r12   = coef[5];
  assign xform.r20   = coef[6];
  assign xform.r21   = coef[7];
  assign xform.r22   = coef[8];
  assign xform.out_x = mv_out[0];
  assign xform.out_y = mv_out[1];
  assign xform.out_z = mv_out[2];

  // checks
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !xform.valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(row_vld))
    else $error("cell row moved during a stall");

  a_sat_row0: assert property (@(posedge clk) disable iff (rst)
    xform.valid |-> (xform.r00 <= COEF_LIM && xform.r00 >= -COEF_LIM &&
                     xform.r01 <= COEF_LIM && xform.r01 >= -COEF_LIM &&
                     xform.r02 <= COEF_LIM && xform.r02 >= -COEF_LIM))
    else $error("row 0 coefficient out of range");

  a_sat_row2: assert property (@(posedge clk) disable iff (rst)
    xform.valid |-> (xform.r20 <= COEF_LIM && xform.r20 >= -COEF_LIM &&
                     xform.r21 <= COEF_LIM && xform.r21 >= -COEF_LIM &&
                     xform.r22 <= COEF_LIM && xform.r22 >= -COEF_LIM))
    else $error("row 2 coefficient out of range");

endmodule
